// ===== rtl/core/pba_pkg.sv =====
package pba_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned DistWidth  = 10;

  typedef enum logic [1:0] {
    MODE_NORMAL     = 2'd0,
    MODE_CONTINUOUS = 2'd1,
    MODE_SINGLE     = 2'd2,
    MODE_ADJUST     = 2'd3
  } pba_mode_t;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_UPDATE = 1'b1
  } pba_op_t;

  typedef enum logic {
    REG_ON_TICKS    = 1'b0,
    REG_IDLE_PERIOD = 1'b1
  } pba_reg_t;

  typedef struct packed {
    pba_op_t                opcode;
    pba_mode_t              mode;
    logic [DistWidth-1:0]   distance;
    logic                   object_seen;
    logic                   pulse_request;
  } pba_item_t;

  typedef struct packed {
    logic [CountWidth-1:0] on_ticks;
    logic [CountWidth-1:0] idle_period;
  } pba_cfg_t;

  localparam logic [CountWidth-1:0] ResetOnTicks    = 16'd500;
  localparam logic [CountWidth-1:0] ResetIdlePeriod = 16'd50000;

  localparam logic [DistWidth-1:0] Dist250 = 10'd250;
  localparam logic [DistWidth-1:0] Dist200 = 10'd200;
  localparam logic [DistWidth-1:0] Dist100 = 10'd100;
  localparam logic [DistWidth-1:0] Dist50  = 10'd50;
  localparam logic [DistWidth-1:0] Dist25  = 10'd25;
  localparam logic [DistWidth-1:0] Dist10  = 10'd10;
  localparam logic [DistWidth-1:0] Dist5   = 10'd5;

  localparam logic [CountWidth-1:0] Period3500 = 16'd3500;
  localparam logic [CountWidth-1:0] Period3000 = 16'd3000;
  localparam logic [CountWidth-1:0] Period2500 = 16'd2500;
  localparam logic [CountWidth-1:0] Period2000 = 16'd2000;
  localparam logic [CountWidth-1:0] Period1500 = 16'd1500;
  localparam logic [CountWidth-1:0] Period1000 = 16'd1000;
  localparam logic [CountWidth-1:0] Period750  = 16'd750;
  localparam logic [CountWidth-1:0] Period500  = 16'd500;

endpackage

// ===== rtl/core/pba_period.sv =====
module pba_period (
  input  pba_pkg::pba_mode_t                 mode,
  input  logic [pba_pkg::DistWidth-1:0]      distance,
  input  logic [pba_pkg::CountWidth-1:0]     idle_period,
  output logic [pba_pkg::CountWidth-1:0]     period
);

  always_comb begin
    if (mode != pba_pkg::MODE_NORMAL) begin
      period = idle_period;
    end else if (distance >= pba_pkg::Dist250) begin
      period = pba_pkg::Period3500;
    end else if (distance >= pba_pkg::Dist200) begin
      period = pba_pkg::Period3000;
    end else if (distance >= pba_pkg::Dist100) begin
      period = pba_pkg::Period2500;
    end else if (distance >= pba_pkg::Dist50) begin
      period = pba_pkg::Period2000;
    end else if (distance >= pba_pkg::Dist25) begin
      period = pba_pkg::Period1500;
    end else if (distance >= pba_pkg::Dist10) begin
      period = pba_pkg::Period1000;
    end else if (distance >= pba_pkg::Dist5) begin
      period = pba_pkg::Period750;
    end else begin
      period = pba_pkg::Period500;
    end
  end

endmodule

// ===== rtl/core/pba_core.sv =====
module pba_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  pba_pkg::pba_item_t item,
  input  pba_pkg::pba_cfg_t  cfg,
  output logic               buzzer,
  output logic               led
);

  logic [pba_pkg::CountWidth-1:0] tick_count;
  logic [pba_pkg::CountWidth-1:0] tick_count_next;
  logic [pba_pkg::CountWidth-1:0] period_length;
  logic [pba_pkg::CountWidth-1:0] period_length_next;
  logic [pba_pkg::CountWidth-1:0] new_period;
  logic [pba_pkg::CountWidth-1:0] count_inc;
  logic tone_active;
  logic tone_active_next;
  logic flash_pending;
  logic flash_pending_next;
  logic toggle_phase;
  logic toggle_phase_next;
  logic buzzer_next;
  logic led_next;
  logic in_window;

  pba_period u_period (
    .mode        (item.mode),
    .distance    (item.distance),
    .idle_period (cfg.idle_period),
    .period      (new_period)
  );

  assign in_window = tick_count <= cfg.on_ticks;
  assign count_inc = tick_count + 1'b1;

  always_comb begin
    tick_count_next    = tick_count;
    period_length_next = period_length;
    tone_active_next   = tone_active;
    flash_pending_next = flash_pending;
    toggle_phase_next  = toggle_phase;
    buzzer_next        = buzzer;
    led_next           = led;
    if (item.opcode == pba_pkg::OP_UPDATE) begin
      period_length_next = new_period;
      case (item.mode)
        pba_pkg::MODE_CONTINUOUS: begin
          tone_active_next = 1'b1;
          tick_count_next  = '0;
        end
        pba_pkg::MODE_SINGLE: begin
          if (item.pulse_request) begin
            tone_active_next   = 1'b1;
            flash_pending_next = 1'b1;
            tick_count_next    = '0;
          end
        end
        pba_pkg::MODE_ADJUST: begin
          tone_active_next = 1'b0;
        end
        default: begin
        end
      endcase
    end else begin
      if (tone_active && in_window) begin
        buzzer_next       = toggle_phase;
        toggle_phase_next = !toggle_phase;
      end
      led_next           = flash_pending;
      flash_pending_next = 1'b0;
      if (!in_window) begin
        tone_active_next = 1'b0;
      end
      if (count_inc >= period_length) begin
        tick_count_next = '0;
        if (item.object_seen && item.mode == pba_pkg::MODE_NORMAL) begin
          tone_active_next   = 1'b1;
          flash_pending_next = 1'b1;
        end
      end else begin
        tick_count_next = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      period_length <= pba_pkg::ResetIdlePeriod;
      tone_active   <= 1'b0;
      flash_pending <= 1'b0;
      toggle_phase  <= 1'b0;
      buzzer        <= 1'b0;
      led           <= 1'b0;
    end else if (step) begin
      tick_count    <= tick_count_next;
      period_length <= period_length_next;
      tone_active   <= tone_active_next;
      flash_pending <= flash_pending_next;
      toggle_phase  <= toggle_phase_next;
      buzzer        <= buzzer_next;
      led           <= led_next;
    end
  end

  a_led_follows_flash: assert property (@(posedge clk) disable iff (rst)
    step && item.opcode == pba_pkg::OP_TICK |=> led == $past(flash_pending))
    else $error("LED level does not match the armed flash after a tick.");

  a_update_keeps_outputs: assert property (@(posedge clk) disable iff (rst)
    step && item.opcode == pba_pkg::OP_UPDATE |=> $stable(buzzer) && $stable(led))
    else $error("Outputs changed on a mode update.");

  a_count_wraps: assert property (@(posedge clk) disable iff (rst)
    step && item.opcode == pba_pkg::OP_TICK
    |=> tick_count < period_length || tick_count == '0)
    else $error("Tick count passed the period length.");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(tick_count) && $stable(tone_active) && $stable(buzzer))
    else $error("State changed without an accepted item.");

endmodule

// ===== rtl/core/proximity_beep_alarm_timer.sv =====
// Proximity alarm beeper. Every input item (a timer tick or a mode update)
// produces exactly one result item carrying the buzzer and LED levels after
// that item. The block takes one item per clock cycle unless m_tready stalls the
// output: the state update is a single pass of logic into the state registers,
// which directly hold the result, and an output valid flag lets a new item enter
// in the same cycle that the previous result is taken. Configuration writes are
// always ready and should be issued only while no result is pending.
module proximity_beep_alarm_timer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: mode[1:0], distance[11:2], object_seen[12], pulse_request[13], zero[15:14]
  input  logic [15:0] s_tdata,
  // tuser: opcode[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: buzzer_level[0], led_level[1], zero[7:2]
  output logic [7:0]  m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  pba_pkg::pba_item_t item;
  pba_pkg::pba_cfg_t  cfg;
  logic               step;
  logic               buzzer;
  logic               led;

  assign item.opcode        = pba_pkg::pba_op_t'(s_tuser);
  assign item.mode          = pba_pkg::pba_mode_t'(s_tdata[1:0]);
  assign item.distance      = s_tdata[11:2];
  assign item.object_seen   = s_tdata[12];
  assign item.pulse_request = s_tdata[13];

  assign s_tready  = !m_tvalid || m_tready;
  assign step      = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_ticks    <= pba_pkg::ResetOnTicks;
      cfg.idle_period <= pba_pkg::ResetIdlePeriod;
    end else if (cfg_valid) begin
      case (pba_pkg::pba_reg_t'(cfg_index))
        pba_pkg::REG_ON_TICKS:    cfg.on_ticks    <= cfg_data;
        pba_pkg::REG_IDLE_PERIOD: cfg.idle_period <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  pba_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .buzzer (buzzer),
    .led    (led)
  );

  assign m_tdata = {6'b0, led, buzzer};

endmodule
